[hdl/m2bi_pkg.sv]
// Shared types and constants of the 2D bilinear calibration map.
package m2bi_pkg;

    // Item kinds carried on the command channel
    typedef enum logic [1:0]
    {
        KIND_ROW_KEY,
        KIND_COL_KEY,
        KIND_CELL,
        KIND_LOOKUP
    } kind_t;

    // Configuration register indexes
    typedef enum logic
    {
        REG_ROWS_IN_USE,
        REG_COLS_IN_USE
    } reg_idx_t;

    localparam int Q_W       = 32;     // Q16.16 word
    localparam int FRAC_BITS = 16;
    localparam int T_W       = 17;     // fraction 0 .. 1.0 in Q1.16
    localparam int CFG_W     = 5;
    localparam int IDX_W     = 4;
    localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_BITS);

endpackage

[hdl/m2bi_if.sv]
// Valid/ready channel interfaces for map commands and results.
interface m2bi_cmd_if;
    import m2bi_pkg::*;

    logic                    valid;
    logic                    ready;
    kind_t                   kind;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [Q_W-1:0]   write_value;
    logic signed [Q_W-1:0]   row_key;
    logic signed [Q_W-1:0]   col_key;

    modport source (output valid, kind, row_index, col_index, write_value, row_key, col_key,
                    input ready);
    modport sink   (input valid, kind, row_index, col_index, write_value, row_key, col_key,
                    output ready);
endinterface

interface m2bi_rsp_if;
    import m2bi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [Q_W-1:0]   result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

[hdl/m2bi_locate.sv]
// Clamped breakpoint interval search with parallel comparators.
module m2bi_locate #(
    parameter int N = 16
) (
    input  logic signed [m2bi_pkg::Q_W-1:0]  keys [N],
    input  logic [$clog2(N+1)-1:0]           count,
    input  logic signed [m2bi_pkg::Q_W-1:0]  key,
    output logic [$clog2(N)-1:0]             lo,
    output logic [$clog2(N)-1:0]             hi,
    output logic signed [m2bi_pkg::Q_W-1:0]  k_lo,
    output logic signed [m2bi_pkg::Q_W-1:0]  k_hi,
    output logic                             span
);
    import m2bi_pkg::*;

    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N+1);

    logic [N-2:0]   hit;
    logic [IW-1:0]  first_idx;
    logic           found;
    logic [IW-1:0]  last_idx;

    // Compare the key against every interval in parallel
    always_comb
    begin
        for (int i = 0; i < N - 1; i++)
        begin
            hit[i] = (int'(count) > i + 1) && (key >= keys[i]) && (key <= keys[i+1]);
        end
    end

    // Pick the lowest interval that holds the key
    always_comb
    begin
        first_idx = '0;
        found     = 1'b0;
        for (int i = N - 2; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first_idx = IW'(i);
                found     = 1'b1;
            end
        end
    end

    assign last_idx = IW'(count - CW'(1));

    // Clamp at both ends, else take the interval found
    always_comb
    begin
        lo   = '0;
        hi   = '0;
        span = 1'b0;
        if ((count < CW'(2)) || (key <= keys[0]))
        begin
            lo = '0;
            hi = '0;
        end
        else if (key >= keys[last_idx])
        begin
            lo = last_idx;
            hi = last_idx;
        end
        else if (found)
        begin
            lo   = first_idx;
            hi   = IW'(first_idx + 1'b1);
            span = 1'b1;
        end
        else
        begin
            lo = last_idx;
            hi = last_idx;
        end
    end

    assign k_lo = keys[lo];
    assign k_hi = keys[hi];

endmodule

[hdl/map_2d_bilinear_interp.sv]
// Top level of the 2D bilinear calibration map engine.
//
// Usage: items arrive on the cmd channel (valid/ready). Kinds ROW_KEY,
// COL_KEY and CELL store write_value at row_index/col_index and return
// nothing; a LOOKUP returns one interpolated Q16.16 value on rsp.
// rows_in_use and cols_in_use are set through cfg_we/cfg_index/cfg_data
// while the engine is idle; write breakpoints in ascending order.
// Pipeline: one input register, one stage for the interval search and
// cell reads, 17 for the restoring divider that forms the Q1.16
// fractions (one quotient bit per stage, the first also takes the
// interval width), and four for the column and row blends.
// Throughput: one item per cycle while rsp does not stall; a write takes effect at its transaction.
// Reset clears the sizes in use and all valid bits; stores hold their
// contents undefined until written. When rsp stalls, the whole pipeline
// holds and cmd.ready drops until the waiting result is taken.
module map_2d_bilinear_interp #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    m2bi_cmd_if.sink                       cmd,
    m2bi_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [m2bi_pkg::CFG_W-1:0]     cfg_data
);
    import m2bi_pkg::*;

    localparam int RIW       = $clog2(MAX_ROWS);
    localparam int CIW       = $clog2(MAX_COLS);
    localparam int RCW       = $clog2(MAX_ROWS + 1);
    localparam int CCW       = $clog2(MAX_COLS + 1);
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int AW        = $clog2(CELLS);
    localparam int DIV_STEPS = T_W;
    localparam int P_W       = Q_W + 1 + T_W + 1;

    typedef struct packed {
        logic              empty;
        logic [Q_W-1:0]    rrem;
        logic [Q_W-1:0]    rden;
        logic [T_W-1:0]    rq;
        logic [Q_W-1:0]    crem;
        logic [Q_W-1:0]    cden;
        logic [T_W-1:0]    cq;
        logic signed [Q_W-1:0] c00;
        logic signed [Q_W-1:0] c01;
        logic signed [Q_W-1:0] c10;
        logic signed [Q_W-1:0] c11;
    } div_t;

    typedef struct packed {
        logic [Q_W-1:0]    rem;
        logic [T_W-1:0]    q;
    } dstep_t;

    // One restoring division step: the first step compares without a shift
    function automatic dstep_t div_step(input logic [Q_W-1:0] rem, input logic [Q_W-1:0] den,
                                        input logic [T_W-1:0] q, input logic first);
        logic [Q_W:0] trial;
        dstep_t       r;
        trial = first ? {1'b0, rem} : {rem, 1'b0};
        if (trial >= {1'b0, den})
        begin
            r.rem = Q_W'(trial - {1'b0, den});
            r.q   = {q[T_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[Q_W-1:0];
            r.q   = {q[T_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Configuration and stores
    logic [CFG_W-1:0]       rows_in_use_reg;
    logic [CFG_W-1:0]       cols_in_use_reg;
    logic signed [Q_W-1:0]  row_bp_reg [MAX_ROWS];
    logic signed [Q_W-1:0]  col_bp_reg [MAX_COLS];
    logic signed [Q_W-1:0]  cell_mem0 [CELLS];
    logic signed [Q_W-1:0]  cell_mem1 [CELLS];
    logic signed [Q_W-1:0]  cell_mem2 [CELLS];
    logic signed [Q_W-1:0]  cell_mem3 [CELLS];

    logic                   adv;
    logic                   acc;
    logic                   cell_we;
    logic [AW-1:0]          wr_addr;

    // Stage A: accepted lookup
    logic                   a_valid_reg;
    logic signed [Q_W-1:0]  a_row_key_reg;
    logic signed [Q_W-1:0]  a_col_key_reg;
    logic [RCW-1:0]         nr;
    logic [CCW-1:0]         nc;
    logic [RIW-1:0]         r_lo, r_hi;
    logic [CIW-1:0]         c_lo, c_hi;
    logic signed [Q_W-1:0]  rk_lo, rk_hi, ck_lo, ck_hi;
    logic                   r_span, c_span;
    logic [AW-1:0]          addr00, addr01, addr10, addr11;

    // Stage B: selected breakpoints and cells
    logic                   b_valid_reg;
    logic                   b_empty_reg;
    logic signed [Q_W-1:0]  b_row_key_reg, b_col_key_reg;
    logic signed [Q_W-1:0]  b_rk_lo_reg, b_rk_hi_reg, b_ck_lo_reg, b_ck_hi_reg;
    logic                   b_r_span_reg, b_c_span_reg;
    logic signed [Q_W-1:0]  b_c00_reg, b_c01_reg, b_c10_reg, b_c11_reg;
    logic signed [Q_W:0]    r_d, r_n, c_d, c_n;
    div_t                   b_div;

    // Divider stages
    logic [DIV_STEPS-1:0]   div_valid_reg;
    div_t                   div_reg  [DIV_STEPS];
    div_t                   div_next [DIV_STEPS];

    // Blend stages
    logic                   m1_valid_reg, m2_valid_reg, m3_valid_reg;
    logic                   m1_empty_reg, m2_empty_reg, m3_empty_reg;
    logic [T_W-1:0]         m1_rt_reg, m2_rt_reg;
    logic signed [Q_W-1:0]  m1_top_a_reg, m1_bot_a_reg;
    logic signed [P_W-1:0]  m1_ptop_reg, m1_pbot_reg;
    logic signed [Q_W-1:0]  m2_top_reg, m2_bot_reg, m3_top_reg;
    logic signed [P_W-1:0]  m3_p_reg;
    logic                   out_valid_reg;
    logic signed [Q_W-1:0]  out_result_reg;
    div_t                   last_div;

    // Advance the whole pipeline unless a result waits unclaimed
    assign adv       = !out_valid_reg || rsp.ready;
    assign cmd.ready = adv;
    assign acc       = cmd.valid && adv;
    assign rsp.valid  = out_valid_reg;
    assign rsp.result = out_result_reg;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= '0;
            cols_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data;
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_data;
                default:         rows_in_use_reg <= rows_in_use_reg;
            endcase
        end
    end

    // Write breakpoints at the transaction that carries them
    always_ff @(posedge clk)
    begin
        if (acc && (cmd.kind == KIND_ROW_KEY) && (int'(cmd.row_index) < MAX_ROWS))
        begin
            row_bp_reg[RIW'(cmd.row_index)] <= cmd.write_value;
        end
        if (acc && (cmd.kind == KIND_COL_KEY) && (int'(cmd.col_index) < MAX_COLS))
        begin
            col_bp_reg[CIW'(cmd.col_index)] <= cmd.write_value;
        end
    end

    // Cell memory: four copies give four reads a cycle
    assign cell_we = acc && (cmd.kind == KIND_CELL) && (int'(cmd.row_index) < MAX_ROWS)
                     && (int'(cmd.col_index) < MAX_COLS);
    assign wr_addr = AW'(int'(cmd.row_index) * MAX_COLS + int'(cmd.col_index));

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem0[wr_addr] <= cmd.write_value;
            cell_mem1[wr_addr] <= cmd.write_value;
            cell_mem2[wr_addr] <= cmd.write_value;
            cell_mem3[wr_addr] <= cmd.write_value;
        end
        if (adv)
        begin
            b_c00_reg <= cell_mem0[addr00];
            b_c01_reg <= cell_mem1[addr01];
            b_c10_reg <= cell_mem2[addr10];
            b_c11_reg <= cell_mem3[addr11];
        end
    end

    // Stage A: saturate sizes and search both axes
    assign nr = (int'(rows_in_use_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_in_use_reg);
    assign nc = (int'(cols_in_use_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_in_use_reg);

    m2bi_locate #(.N(MAX_ROWS)) u_row_locate (
        .keys  (row_bp_reg),
        .count (nr),
        .key   (a_row_key_reg),
        .lo    (r_lo),
        .hi    (r_hi),
        .k_lo  (rk_lo),
        .k_hi  (rk_hi),
        .span  (r_span)
    );

    m2bi_locate #(.N(MAX_COLS)) u_col_locate (
        .keys  (col_bp_reg),
        .count (nc),
        .key   (a_col_key_reg),
        .lo    (c_lo),
        .hi    (c_hi),
        .k_lo  (ck_lo),
        .k_hi  (ck_hi),
        .span  (c_span)
    );

    assign addr00 = AW'(int'(r_lo) * MAX_COLS + int'(c_lo));
    assign addr01 = AW'(int'(r_lo) * MAX_COLS + int'(c_hi));
    assign addr10 = AW'(int'(r_hi) * MAX_COLS + int'(c_lo));
    assign addr11 = AW'(int'(r_hi) * MAX_COLS + int'(c_hi));

    // Stage B: interval width and offset; force t to zero off an interval or on one of zero width
    always_comb
    begin
        r_d = (Q_W+1)'(b_rk_hi_reg) - (Q_W+1)'(b_rk_lo_reg);
        r_n = (Q_W+1)'(b_row_key_reg) - (Q_W+1)'(b_rk_lo_reg);
        c_d = (Q_W+1)'(b_ck_hi_reg) - (Q_W+1)'(b_ck_lo_reg);
        c_n = (Q_W+1)'(b_col_key_reg) - (Q_W+1)'(b_ck_lo_reg);
        b_div.empty = b_empty_reg;
        b_div.rq    = '0;
        b_div.cq    = '0;
        b_div.c00   = b_c00_reg;
        b_div.c01   = b_c01_reg;
        b_div.c10   = b_c10_reg;
        b_div.c11   = b_c11_reg;
        if (b_r_span_reg && (r_d > 0))
        begin
            b_div.rrem = r_n[Q_W-1:0];
            b_div.rden = r_d[Q_W-1:0];
        end
        else
        begin
            b_div.rrem = '0;
            b_div.rden = Q_W'(1);
        end
        if (b_c_span_reg && (c_d > 0))
        begin
            b_div.crem = c_n[Q_W-1:0];
            b_div.cden = c_d[Q_W-1:0];
        end
        else
        begin
            b_div.crem = '0;
            b_div.cden = Q_W'(1);
        end
    end

    // Divider: one quotient bit per stage for both fractions
    always_comb
    begin
        div_t   src;
        dstep_t rs;
        dstep_t cs;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            src = (j == 0) ? b_div : div_reg[(j == 0) ? 0 : j - 1];
            rs  = div_step(src.rrem, src.rden, src.rq, j == 0);
            cs  = div_step(src.crem, src.cden, src.cq, j == 0);
            div_next[j]      = src;
            div_next[j].rrem = rs.rem;
            div_next[j].rq   = rs.q;
            div_next[j].crem = cs.rem;
            div_next[j].cq   = cs.q;
        end
    end

    assign last_div = div_reg[DIV_STEPS-1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            div_valid_reg <= '0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= acc && (cmd.kind == KIND_LOOKUP);
            b_valid_reg   <= a_valid_reg;
            div_valid_reg <= {div_valid_reg[DIV_STEPS-2:0], b_valid_reg};
            m1_valid_reg  <= div_valid_reg[DIV_STEPS-1];
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            out_valid_reg <= m3_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_row_key_reg <= cmd.row_key;
            a_col_key_reg <= cmd.col_key;

            b_empty_reg   <= (nr == '0) || (nc == '0);
            b_row_key_reg <= a_row_key_reg;
            b_col_key_reg <= a_col_key_reg;
            b_rk_lo_reg   <= rk_lo;
            b_rk_hi_reg   <= rk_hi;
            b_ck_lo_reg   <= ck_lo;
            b_ck_hi_reg   <= ck_hi;
            b_r_span_reg  <= r_span;
            b_c_span_reg  <= c_span;

            for (int j = 0; j < DIV_STEPS; j++)
            begin
                div_reg[j] <= div_next[j];
            end

            // Column blend products
            m1_empty_reg <= last_div.empty;
            m1_rt_reg    <= last_div.rq;
            m1_top_a_reg <= last_div.c00;
            m1_bot_a_reg <= last_div.c10;
            m1_ptop_reg  <= P_W'(((Q_W+1)'(last_div.c01) - (Q_W+1)'(last_div.c00))
                                 * $signed({1'b0, last_div.cq}));
            m1_pbot_reg  <= P_W'(((Q_W+1)'(last_div.c11) - (Q_W+1)'(last_div.c10))
                                 * $signed({1'b0, last_div.cq}));

            // Column blend sums
            m2_empty_reg <= m1_empty_reg;
            m2_rt_reg    <= m1_rt_reg;
            m2_top_reg   <= Q_W'(P_W'(m1_top_a_reg) + (m1_ptop_reg >>> FRAC_BITS));
            m2_bot_reg   <= Q_W'(P_W'(m1_bot_a_reg) + (m1_pbot_reg >>> FRAC_BITS));

            // Row blend product
            m3_empty_reg <= m2_empty_reg;
            m3_top_reg   <= m2_top_reg;
            m3_p_reg     <= P_W'(((Q_W+1)'(m2_bot_reg) - (Q_W+1)'(m2_top_reg))
                                 * $signed({1'b0, m2_rt_reg}));

            // Row blend sum, empty map gives zero
            out_result_reg <= m3_empty_reg ? '0
                              : Q_W'(P_W'(m3_top_reg) + (m3_p_reg >>> FRAC_BITS));
        end
    end

    // Divider leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[DIV_STEPS-1] |-> (last_div.rrem < last_div.rden)
                                       && (last_div.crem < last_div.cden))
        else $error("divider remainder not below divisor");

    // Fractions never exceed one
    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[DIV_STEPS-1] |-> (last_div.rq <= T_ONE) && (last_div.cq <= T_ONE))
        else $error("fraction above one");

    // A row interval found spans two neighboring breakpoints
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && r_span) |-> (int'(r_hi) == int'(r_lo) + 1))
        else $error("row interval indexes not adjacent");

    // A result appears only from a lookup in the last blend stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(m3_valid_reg))
        else $error("result without lookup");

    // Input is held exactly while a result waits unclaimed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready == (!rsp.valid || rsp.ready))
        else $error("input ready does not follow output stall");

endmodule

[tb/tb_map_2d_bilinear_interp.sv]
// Testbench for the 2D bilinear calibration map: scoreboard class, drivers and checks.
module tb_map_2d_bilinear_interp;
    timeunit 1ns;
    timeprecision 1ps;

    import m2bi_pkg::*;

    localparam int NROW = 16;
    localparam int NCOL = 16;
    localparam int LATENCY = 24;
    localparam longint CYCLE_LIMIT = 400000;

    // Track the map contents and the lookup results still owed by the engine
    class map_scoreboard;
        logic signed [31:0] row_bp [NROW];
        logic signed [31:0] col_bp [NCOL];
        logic signed [31:0] cells [NROW*NCOL];
        logic [4:0] rows_cfg;
        logic [4:0] cols_cfg;
        logic signed [31:0] pending_results [$];
        int mismatches;

        function void clear();
            rows_cfg = '0;
            cols_cfg = '0;
            mismatches = 0;
            foreach (row_bp[i]) row_bp[i] = '0;
            foreach (col_bp[i]) col_bp[i] = '0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [4:0] val);
            if (idx == REG_ROWS_IN_USE) rows_cfg = val;
            else cols_cfg = val;
        endfunction

        // Clamped interval search giving lower and upper index and Q1.16 fraction
        function void seek_span(input logic signed [31:0] keys [16], input int count,
                                input logic signed [31:0] key, output int lo,
                                output int hi, output longint frac);
            longint d;
            frac = 0;
            if (count < 2 || key <= keys[0]) begin lo = 0; hi = 0; return; end
            if (key >= keys[count-1]) begin lo = count-1; hi = count-1; return; end
            for (int i = 0; i < count-1; i++)
            begin
                if (key >= keys[i] && key <= keys[i+1])
                begin
                    d = longint'(keys[i+1]) - longint'(keys[i]);
                    lo = i;
                    hi = i+1;
                    if (d > 0) frac = ((longint'(key) - longint'(keys[i])) * 65536) / d;
                    return;
                end
            end
            lo = count-1;
            hi = count-1;
        endfunction

        function longint mix(longint a, longint b, longint frac);
            longint p;
            p = (b - a) * frac;
            return a + (p >>> 16);
        endfunction

        function void note_input(kind_t k, logic [3:0] ri, logic [3:0] ci,
                                 logic signed [31:0] wv, logic signed [31:0] rk,
                                 logic signed [31:0] ck);
            int nr, nc, r0, r1, c0, c1;
            longint rt, ct, upper, lower;
            case (k)
                KIND_ROW_KEY: row_bp[ri] = wv;
                KIND_COL_KEY: col_bp[ci] = wv;
                KIND_CELL:    cells[ri*NCOL + ci] = wv;
                default:
                begin
                    nr = rows_cfg > NROW ? NROW : rows_cfg;
                    nc = cols_cfg > NCOL ? NCOL : cols_cfg;
                    if (nr < 1 || nc < 1)
                        pending_results.push_back('0);
                    else
                    begin
                        seek_span(row_bp, nr, rk, r0, r1, rt);
                        seek_span(col_bp, nc, ck, c0, c1, ct);
                        upper = mix(cells[r0*NCOL+c0], cells[r0*NCOL+c1], ct);
                        lower = mix(cells[r1*NCOL+c0], cells[r1*NCOL+c1], ct);
                        pending_results.push_back(32'(mix(upper, lower, rt)));
                    end
                end
            endcase
        endfunction

        function void check_result(logic signed [31:0] got);
            logic signed [31:0] want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10) $display("result mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;
    longint cycles;
    bit sink_busy;

    m2bi_cmd_if cmd ();
    m2bi_rsp_if rsp ();

    map_2d_bilinear_interp i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    map_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles and stop a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_map_2d_bilinear_interp: FAIL");
                $finish;
            end
        end
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready) sb.check_result(rsp.result);
    end

    // Stall the result channel on its own pattern
    initial
    begin
        int mode;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60))
            begin
                @(posedge clk);
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp.ready <= 1'($urandom_range(0, 1));
                    default: rsp.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    int burst_left;

    // Send one command transaction, with bursts and random gaps
    task automatic send_item(kind_t k, logic [3:0] ri, logic [3:0] ci,
                             logic signed [31:0] wv, logic signed [31:0] rk,
                             logic signed [31:0] ck);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0)
            begin
                cmd.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        cmd.valid       <= 1'b1;
        cmd.kind        <= k;
        cmd.row_index   <= ri;
        cmd.col_index   <= ci;
        cmd.write_value <= wv;
        cmd.row_key     <= rk;
        cmd.col_key     <= ck;
        do @(posedge clk); while (!cmd.ready);
        sb.note_input(k, ri, ci, wv, rk, ck);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Write one register, then release the write enable
    task automatic write_reg(reg_idx_t idx, logic [4:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'(signed'($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    // Load ascending (or sometimes unsorted) breakpoints and all cells
    task automatic load_map(bit sorted);
        logic signed [31:0] k;
        int stepmax;
        stepmax = $urandom_range(0, 1) ? 300000 : 30000000;
        k = 32'(signed'($urandom_range(0, 400000)) - 1000000);
        for (int i = 0; i < NROW; i++)
        begin
            send_item(KIND_ROW_KEY, 4'(i), 4'($urandom), sorted ? k : any_word(), 0, 0);
            k = k + $urandom_range(0, stepmax);
        end
        k = 32'(signed'($urandom_range(0, 400000)) - 1000000);
        for (int i = 0; i < NCOL; i++)
        begin
            send_item(KIND_COL_KEY, 4'($urandom), 4'(i), sorted ? k : any_word(), 0, 0);
            k = k + $urandom_range(0, stepmax);
        end
        for (int r = 0; r < NROW; r++)
            for (int c = 0; c < NCOL; c++)
                send_item(KIND_CELL, 4'(r), 4'(c), any_word(), 0, 0);
    endtask

    function automatic logic signed [31:0] pick_key(logic signed [31:0] keys [16], int n);
        int i;
        i = $urandom_range(0, (n > 0 ? n : 1) - 1);
        case ($urandom_range(0, 5))
            0: return keys[i];
            1: return 32'sh80000000;
            2: return 32'sh7fffffff;
            3: return $urandom;
            default: return keys[i] + $urandom_range(0, 2000000);
        endcase
    endfunction

    task automatic lookups(int count);
        for (int n = 0; n < count; n++)
            send_item(KIND_LOOKUP, 4'($urandom), 4'($urandom), $urandom,
                      pick_key(sb.row_bp, sb.rows_cfg > 16 ? 16 : sb.rows_cfg),
                      pick_key(sb.col_bp, sb.cols_cfg > 16 ? 16 : sb.cols_cfg));
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        burst_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROWS_IN_USE;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.kind = KIND_ROW_KEY;
        cmd.row_index = '0;
        cmd.col_index = '0;
        cmd.write_value = '0;
        cmd.row_key = '0;
        cmd.col_key = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty map answers zero, even with stores unwritten
        send_item(KIND_LOOKUP, 4'hf, 4'hf, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        drain();
        write_reg(REG_ROWS_IN_USE, 5'd16);
        write_reg(REG_COLS_IN_USE, 5'd0);
        send_item(KIND_LOOKUP, 4'h0, 4'h0, 0, 0, 0);

        // Fill the whole map, then directed lookups at edges and extremes
        load_map(1'b1);
        drain();
        write_reg(REG_COLS_IN_USE, 5'd31);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, 32'sh80000000, 32'sh80000000);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, 32'sh7fffffff, 32'sh7fffffff);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, sb.row_bp[15], sb.col_bp[0]);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, sb.row_bp[3], sb.col_bp[4]);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, sb.row_bp[3] + 1, sb.col_bp[4] + 7);
        // Equal neighboring breakpoints give zero width
        send_item(KIND_ROW_KEY, 4'd5, 4'd0, sb.row_bp[4], 0, 0);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, sb.row_bp[4], sb.col_bp[2] + 3);
        drain();
        write_reg(REG_ROWS_IN_USE, 5'd1);
        write_reg(REG_COLS_IN_USE, 5'd2);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, sb.row_bp[0] + 100, sb.col_bp[1] - 1);
        send_item(KIND_LOOKUP, 4'd0, 4'd0, 0, 32'sh7fffffff, 32'sh80000000);

        // Random phases across sizes, some with a fresh map or six random writes
        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            case (ph)
                0: begin write_reg(REG_ROWS_IN_USE, 5'd16); write_reg(REG_COLS_IN_USE, 5'd16); end
                1: begin write_reg(REG_ROWS_IN_USE, 5'd31); write_reg(REG_COLS_IN_USE, 5'd17); end
                2: begin write_reg(REG_ROWS_IN_USE, 5'd0);  write_reg(REG_COLS_IN_USE, 5'd5);  end
                default:
                begin
                    write_reg(REG_ROWS_IN_USE, 5'($urandom_range(1, 31)));
                    write_reg(REG_COLS_IN_USE, 5'($urandom_range(1, 31)));
                end
            endcase
            if (ph % 4 == 1) load_map(ph == 5);
            else if (ph % 3 == 0)
                for (int n = 0; n < 6; n++)
                    send_item(kind_t'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                              any_word(), 0, 0);
            lookups(27);
        end

        drain();
        if (sb.mismatches == 0)
            $display("tb_map_2d_bilinear_interp: PASS");
        else
            $display("tb_map_2d_bilinear_interp: FAIL");
        $finish;
    end
endmodule

[filelist.f]
hdl/m2bi_pkg.sv
hdl/m2bi_if.sv
hdl/m2bi_locate.sv
hdl/map_2d_bilinear_interp.sv
tb/tb_map_2d_bilinear_interp.sv
